@@ hdl/sspp_pkg.sv @@
// Shared types and constants for the servo status packet parser.
package sspp_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'hFF;
	localparam int         DATA_W      = 40;

	typedef enum logic [1:0] {
		REG_EXPECTED_ID    = 2'd0,
		REG_BROADCAST_ID   = 2'd1,
		REG_EXPECTED_COUNT = 2'd2,
		REG_HUNT_LIMIT     = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_HEADER  = 3'd1,
		ST_ID_BAD     = 3'd2,
		ST_LEN_BAD    = 3'd3,
		ST_CHKSUM_BAD = 3'd4
	} status_t;

	typedef enum logic [0:0] {
		KIND_PARAM  = 1'b0,
		KIND_STATUS = 1'b1
	} kind_t;

	typedef struct packed {
		logic [7:0] expected_id;
		logic [7:0] broadcast_id;
		logic [7:0] expected_param_count;
		logic [4:0] hunt_limit;
	} cfg_t;

	typedef struct packed {
		kind_t      result_kind;
		logic [7:0] param_byte;
		logic [7:0] param_index;
		status_t    status_code;
		logic [7:0] servo_error;
		logic [7:0] reply_id;
	} result_t;

endpackage

@@ hdl/sspp_cfg.sv @@
// Configuration register file of the servo status packet parser.
module sspp_cfg import sspp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_id          <= 8'd1;
			cfg_q.broadcast_id         <= 8'd254;
			cfg_q.expected_param_count <= 8'd0;
			cfg_q.hunt_limit           <= 5'd20;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_EXPECTED_ID:    cfg_q.expected_id          <= cfg_data;
				REG_BROADCAST_ID:   cfg_q.broadcast_id         <= cfg_data;
				REG_EXPECTED_COUNT: cfg_q.expected_param_count <= cfg_data;
				REG_HUNT_LIMIT:     cfg_q.hunt_limit           <= cfg_data[4:0];
				default:            cfg_q                      <= cfg_q;
			endcase
		end
	end

endmodule

@@ hdl/sspp_core.sv @@
// Packet state machine: one byte per step, at most one result per byte.
module sspp_core import sspp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output logic       res_valid,
	output result_t    res
);

	typedef enum logic [6:0] {
		PH_HUNT   = 7'b0000001,
		PH_SECOND = 7'b0000010,
		PH_ID     = 7'b0000100,
		PH_LEN    = 7'b0001000,
		PH_ERR    = 7'b0010000,
		PH_PARAM  = 7'b0100000,
		PH_SUM    = 7'b1000000
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [4:0] hunt_q, hunt_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] seen_q, seen_d;
	logic [7:0] err_q, err_d;
	logic [7:0] id_q, id_d;

	logic       finish;
	status_t    code;
	logic       chk;
	logic [7:0] sum_add;
	logic [7:0] seen_inc;
	logic       hdr;

	assign hdr      = (rx_byte == HEADER_BYTE);
	assign sum_add  = sum_q + rx_byte;
	assign seen_inc = seen_q + 8'd1;

	always_comb begin
		phase_d   = phase_q;
		hunt_d    = hunt_q;
		sum_d     = sum_q;
		seen_d    = seen_q;
		err_d     = err_q;
		id_d      = id_q;
		finish    = 1'b0;
		code      = ST_OK;
		chk       = 1'b0;
		res_valid = 1'b0;
		res       = '{result_kind: KIND_PARAM, param_byte: rx_byte, param_index: seen_q,
		              status_code: ST_OK, servo_error: err_q, reply_id: id_q};
		unique case (phase_q)
			PH_SECOND: begin
				if (!hdr) begin
					finish = 1'b1;
					code   = ST_NO_HEADER;
				end else begin
					sum_d   = '0;
					phase_d = PH_ID;
				end
			end
			PH_ID: begin
				sum_d = sum_add;
				id_d  = rx_byte;
				if (rx_byte != cfg.expected_id && cfg.expected_id != cfg.broadcast_id) begin
					finish = 1'b1;
					code   = ST_ID_BAD;
				end else begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				sum_d = sum_add;
				if ({1'b0, rx_byte} != {1'b0, cfg.expected_param_count} + 9'd2) begin
					finish = 1'b1;
					code   = ST_LEN_BAD;
				end else begin
					phase_d = PH_ERR;
				end
			end
			PH_ERR: begin
				sum_d   = sum_add;
				err_d   = rx_byte;
				seen_d  = '0;
				phase_d = (cfg.expected_param_count == 8'd0) ? PH_SUM : PH_PARAM;
			end
			PH_PARAM: begin
				if (seen_q >= cfg.expected_param_count) begin
					chk = 1'b1;
				end else begin
					sum_d     = sum_add;
					res_valid = 1'b1;
					seen_d    = seen_inc;
					if (seen_inc >= cfg.expected_param_count)
						phase_d = PH_SUM;
				end
			end
			PH_SUM: chk = 1'b1;
			default: begin
				// hunting for the first header byte
				if (hunt_q < cfg.hunt_limit) begin
					if (hdr)
						phase_d = PH_SECOND;
					else
						hunt_d = hunt_q + 5'd1;
				end else if (!hdr) begin
					finish = 1'b1;
					code   = ST_NO_HEADER;
				end else begin
					sum_d   = '0;
					phase_d = PH_ID;
				end
			end
		endcase
		if (chk) begin
			finish = 1'b1;
			code   = (~sum_q == rx_byte) ? ST_OK : ST_CHKSUM_BAD;
		end
		if (finish) begin
			res_valid = 1'b1;
			res       = '{result_kind: KIND_STATUS, param_byte: 8'd0, param_index: 8'd0,
			              status_code: code, servo_error: err_d, reply_id: id_d};
			phase_d   = PH_HUNT;
			hunt_d    = '0;
			sum_d     = '0;
			seen_d    = '0;
			err_d     = '0;
			id_d      = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			hunt_q  <= '0;
			sum_q   <= '0;
			seen_q  <= '0;
			err_q   <= '0;
			id_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			hunt_q  <= hunt_d;
			sum_q   <= sum_d;
			seen_q  <= seen_d;
			err_q   <= err_d;
			id_q    <= id_d;
		end
	end

endmodule

@@ hdl/sspp_out_reg.sv @@
// Result register on the master side of the servo status packet parser.
module sspp_out_reg import sspp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  result_t           res,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tuser
);

	logic    valid_q;
	result_t res_q;

	assign m_tvalid = valid_q;
	// tdata: param_byte, param_index, status_code, servo_error, reply_id, zero pad
	assign m_tdata  = {5'd0, res_q.reply_id, res_q.servo_error, res_q.status_code,
	                   res_q.param_index, res_q.param_byte};
	assign m_tuser  = res_q.result_kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= res;
	end

endmodule

@@ hdl/servo_status_packet_parser.sv @@
// Servo status packet parser: top level with input register and result register.
// A byte accepted on s_* is held in the input register, stepped through the
// packet state machine, and any result is loaded into the result register on m_*.
// Throughput: one byte per cycle while m_* is free; a result held by m_tready low
// stalls the input, also for bytes that give no result.
// Reset: arst_n clears all control state and restores register defaults
// (expected_id 1, broadcast_id 254, expected_param_count 0, hunt_limit 20).
module servo_status_packet_parser import sspp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // rx_byte
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DATA_W-1:0] m_tdata,   // param_byte, param_index, status_code, servo_error, reply_id
	output logic              m_tuser,   // result_kind
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       step;
	logic       res_valid;
	result_t    res;

	assign step     = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			byte_s1 <= s_tdata;
	end

	sspp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sspp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.rx_byte   (byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	sspp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && res_valid),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
